@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the range table RTL.
// Depends on nothing; bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_CLK_RST(label, clk, prop, msg)
`endif
`endif

@@ hw/rtl/srt_pkg.sv @@
// Package for the sorted range table: status codes, kinds and sizes.
// Depends on nothing.
package srt_pkg;
  localparam int unsigned TableDepthDefault = 16;
  localparam int unsigned AlignBits = 10;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_READ = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_MISALIGNED = 3'd1,
    ST_FULL       = 3'd2,
    ST_OVERLAP    = 3'd3,
    ST_NOT_FOUND  = 3'd4
  } status_t;
endpackage

@@ hw/rtl/srt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module srt_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

@@ hw/rtl/sorted_range_table_add_delete.sv @@
// Sorted range table: add, delete (exact, split, trim) and read of ranges.
// A rejected request, an empty read slot or the unused kind is answered from the check
// state with no RAM read; a read fetches one slot; add and delete scan the table and
// may move entries, each entry taking a read, a wait and an evaluate or write step.
// One item at a time: in_ready is low from acceptance until the result transfers, and
// rises the cycle after. Reset (rst_n, synchronous, active low) empties the table.
module sorted_range_table_add_delete
  import srt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_base_address,
  input  logic [63:0] in_range_size,
  input  logic [3:0]  in_entry_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [4:0]  out_entry_count,
  output logic [63:0] out_read_start,
  output logic [63:0] out_read_end
);
  `include "assert_macros.svh"

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_RD, S_RWAIT, S_EVAL, S_MV_RD, S_MV_WAIT, S_MV_WR,
    S_PUT, S_PUT2, S_DONE
  } state_t;

  state_t        state_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;     // scan index
  logic [CW-1:0] pos_r;     // insert / close / split position
  logic [CW-1:0] mv_r;      // slot being written during a move
  logic          up_r;      // move direction: up opens a hole
  logic [1:0]    kind_r;
  logic [63:0]   first_r, last_r, size_r;
  logic [3:0]    eidx_r;
  logic [63:0]   hold_s_r, hold_e_r; // value to write: insert, split tail, trim or clear
  logic [2:0]    status_r;
  logic [63:0]   rs_r, re_r;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  logic [63:0]   ws_d, we_d, rs_q, re_q;

  srt_ram #(.Width(64), .Depth(TABLE_DEPTH)) u_starts (
    .clk, .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ws_d),
    .rd_addr(ram_ra), .rd_data(rs_q));
  srt_ram #(.Width(64), .Depth(TABLE_DEPTH)) u_ends (
    .clk, .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(we_d),
    .rd_addr(ram_ra), .rd_data(re_q));

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = (state_r == S_DONE);
  assign out_status      = status_r;
  assign out_entry_count = 5'(count_r);
  assign out_read_start  = rs_r;
  assign out_read_end    = re_r;

  // Shared compare unit: one entry against the request each scan step.
  logic hit_ovl, hit_after, hit_cont;
  assign hit_ovl   = (rs_q <= last_r) && (re_q >= first_r);
  assign hit_after = (first_r > re_q);
  assign hit_cont  = (rs_q <= first_r) && (re_q >= last_r);

  // Single shared adder for end computation.
  logic [64:0] last_sum;
  assign last_sum = {1'b0, first_r} + {1'b0, size_r} - 65'd1;

  always_comb begin
    ram_we = 1'b0;
    ram_wa = AW'(mv_r);
    ws_d   = rs_q;
    we_d   = re_q;
    ram_ra = AW'(idx_r);
    unique case (state_r)
      S_MV_RD, S_MV_WAIT: ram_ra = up_r ? AW'(mv_r - 1'b1) : AW'(mv_r + 1'b1);
      S_MV_WR: ram_we = 1'b1;
      S_PUT: begin
        ram_we = 1'b1;
        ram_wa = AW'(pos_r);
        ws_d   = hold_s_r;
        we_d   = hold_e_r;
      end
      S_PUT2: begin
        // split head: entry pos-1 keeps its start, end trims to first-1
        ram_we = 1'b1;
        ram_wa = AW'(pos_r - 1'b1);
        ws_d   = rs_r;
        we_d   = first_r - 64'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          kind_r  <= in_kind;
          first_r <= in_base_address;
          size_r  <= in_range_size;
          eidx_r  <= in_entry_index;
          idx_r   <= CW'(in_entry_index);
          rs_r    <= '0;
          re_r    <= '0;
          status_r <= ST_OK;
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          last_r <= last_sum[63:0];
          pos_r  <= '0;
          if (kind_r == KIND_READ) begin
            if ({1'b0, eidx_r} < 5'(count_r) && 32'(eidx_r) < TABLE_DEPTH)
              state_r <= S_RD;
            else state_r <= S_DONE;
          end else if (kind_r == KIND_NONE) begin
            state_r <= S_DONE;
          end else if (first_r[AlignBits-1:0] != '0 || size_r[AlignBits-1:0] != '0
                       || size_r == '0 || last_sum[64]) begin
            status_r <= ST_MISALIGNED;
            state_r  <= S_DONE;
          end else if (32'(count_r) >= TABLE_DEPTH) begin
            status_r <= ST_FULL;
            state_r  <= S_DONE;
          end else begin
            idx_r   <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_RWAIT; // address presented, data next cycle
        S_RWAIT: state_r <= S_EVAL;
        S_EVAL: begin
          if (kind_r == KIND_READ) begin
            rs_r    <= rs_q;
            re_r    <= re_q;
            state_r <= S_DONE;
          end else if (idx_r >= count_r) begin
            if (kind_r == KIND_DEL) begin
              status_r <= ST_NOT_FOUND;
              state_r  <= S_DONE;
            end else begin
              // add: open a hole at pos
              hold_s_r <= first_r;
              hold_e_r <= last_r;
              up_r     <= 1'b1;
              mv_r     <= count_r;
              count_r  <= count_r + 1'b1;
              state_r  <= (count_r > pos_r) ? S_MV_RD : S_PUT;
            end
          end else if (kind_r == KIND_ADD) begin
            if (hit_ovl) begin
              status_r <= ST_OVERLAP;
              state_r  <= S_DONE;
            end else begin
              if (hit_after) pos_r <= idx_r + 1'b1;
              idx_r   <= idx_r + 1'b1;
              state_r <= S_RD;
            end
          end else if (hit_cont) begin
            if (rs_q == first_r && re_q == last_r) begin
              // remove: shift down from idx, then clear the top slot
              up_r     <= 1'b0;
              mv_r     <= idx_r;
              pos_r    <= count_r - 1'b1;
              hold_s_r <= '0;
              hold_e_r <= '0;
              count_r  <= count_r - 1'b1;
              state_r  <= (idx_r + 1'b1 < count_r) ? S_MV_RD : S_PUT;
            end else if (rs_q != first_r && re_q != last_r) begin
              // split: tail goes into a new slot idx+1, head trimmed after
              hold_s_r <= last_r + 64'd1;
              hold_e_r <= re_q;
              rs_r     <= rs_q;
              pos_r    <= idx_r + 1'b1;
              up_r     <= 1'b1;
              mv_r     <= count_r;
              count_r  <= count_r + 1'b1;
              state_r  <= (count_r > idx_r + 1'b1) ? S_MV_RD : S_PUT;
            end else begin
              // trim one edge in place
              up_r     <= 1'b0;
              pos_r    <= idx_r;
              hold_s_r <= (rs_q != first_r) ? rs_q : last_r + 64'd1;
              hold_e_r <= (rs_q != first_r) ? first_r - 64'd1 : re_q;
              state_r  <= S_PUT;
            end
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_MV_RD: state_r <= S_MV_WAIT;
        S_MV_WAIT: state_r <= S_MV_WR;
        S_MV_WR: begin
          if (up_r) begin
            mv_r    <= mv_r - 1'b1;
            state_r <= (mv_r - 1'b1 > pos_r) ? S_MV_RD : S_PUT;
          end else begin
            mv_r    <= mv_r + 1'b1;
            state_r <= (mv_r + 1'b1 < pos_r) ? S_MV_RD : S_PUT;
          end
        end
        S_PUT: begin
          // split needs its head trimmed too
          if (kind_r == KIND_DEL && up_r) state_r <= S_PUT2;
          else state_r <= S_DONE;
        end
        S_PUT2: begin
          rs_r    <= '0;
          state_r <= S_DONE;
        end
        S_DONE: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_count_max, clk, rst_n, 32'(count_r) <= TABLE_DEPTH, "count above depth")
  `ASSERT_CLK(a_excl, clk, rst_n, !(in_ready && out_valid), "ready while result held")
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_status), "result dropped")
  `ASSERT_CLK(a_cnt_idle, clk, rst_n, in_ready |=> $stable(count_r) || !in_ready, "count moved idle")
endmodule
